// ===== rtl/irqlb_pkg.sv =====
`default_nettype none
package irqlb_pkg;

   // default sizes of the counter table
   localparam int DEF_MAX_CORES   = 16;
   localparam int DEF_IRQ_LINES   = 16;
   localparam int DEF_COUNT_WIDTH = 32;

   // field and register widths
   localparam int CORE_ID_W  = 4;
   localparam int IRQ_ID_W   = 4;
   localparam int PERIOD_W   = 16;
   localparam int ACTIVE_W   = 5;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SYMMETRIC_MODE   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BALANCING_ENABLE = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BALANCE_PERIOD   = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_CORES     = 8'd3;

   // register reset values
   localparam logic [PERIOD_W-1:0] RST_BALANCE_PERIOD = 16'd10;
   localparam logic [ACTIVE_W-1:0] RST_ACTIVE_CORES   = 5'd1;

   // command handed from the front to the engine
   typedef struct packed {
      logic [CORE_ID_W-1:0] core_id;
      logic [IRQ_ID_W-1:0]  irq;
      logic                 allow_balance;
      logic                 in_range;
   } cmd_type;

   // one result item
   typedef struct packed {
      logic                 eoi_to_local_apic;
      logic                 route_valid;
      logic [IRQ_ID_W-1:0]  route_irq;
      logic [CORE_ID_W-1:0] route_core;
      logic                 counts_cleared;
   } rsp_type;

   // remainder unit status
   typedef struct packed {
      logic busy;
      logic done;
      logic zero;
   } rem_status_type;

   // engine sequencer states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_MOD,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_CLEAR,
      ST_DONE
   } engine_state_type;

endpackage
`default_nettype wire

// ===== rtl/irqlb_front.sv =====
`default_nettype none
module irqlb_front #(
   parameter int MAX_CORES = irqlb_pkg::DEF_MAX_CORES,
   parameter int IRQ_LINES = irqlb_pkg::DEF_IRQ_LINES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [irqlb_pkg::CORE_ID_W-1:0]    req_core_id,
   input  logic [irqlb_pkg::IRQ_ID_W-1:0]     req_irq,
   input  logic                               req_allow_balance,
   input  logic                               stall,
   output logic                               cmd_valid,
   output irqlb_pkg::cmd_type                 cmd_head,
   input  logic                               cmd_pop
);
   import irqlb_pkg::*;

   cmd_type    q_ff [2];
   cmd_type    q_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   // classify the incoming interrupt
   always_comb begin
      q_in.core_id       = req_core_id;
      q_in.irq           = req_irq;
      q_in.allow_balance = req_allow_balance;
      q_in.in_range      = (int'(req_core_id) < MAX_CORES) && (int'(req_irq) < IRQ_LINES);
   end

   // queue control
   assign req_full  = (cnt_ff == 2'd2) || stall;
   assign push      = req_push && !req_full;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_head  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= q_in;
      end
   end

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cnt_ff != 2'd0)
      else $error("command popped from empty queue");

endmodule
`default_nettype wire

// ===== rtl/irqlb_rem.sv =====
`default_nettype none
module irqlb_rem #(
   parameter int COUNT_WIDTH = irqlb_pkg::DEF_COUNT_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [COUNT_WIDTH-1:0]          dividend,
   input  logic [irqlb_pkg::PERIOD_W-1:0]  divisor,
   output irqlb_pkg::rem_status_type       status
);
   import irqlb_pkg::*;

   localparam int STEP_W = (COUNT_WIDTH > 1) ? $clog2(COUNT_WIDTH) : 1;

   logic [COUNT_WIDTH-1:0] shift_ff, shift_in;
   logic [PERIOD_W-1:0]    rem_ff, rem_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [PERIOD_W:0]      trial;

   // one restoring step per cycle, msb first
   always_comb begin
      trial    = {rem_ff, shift_ff[COUNT_WIDTH-1]};
      shift_in = shift_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         step_in  = STEP_W'(COUNT_WIDTH - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = shift_ff << 1;
         if (trial >= {1'b0, divisor}) begin
            rem_in = PERIOD_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[PERIOD_W-1:0];
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign status.zero = (rem_ff == '0);

endmodule
`default_nettype wire

// ===== rtl/irqlb_engine.sv =====
`default_nettype none
module irqlb_engine #(
   parameter int MAX_CORES   = irqlb_pkg::DEF_MAX_CORES,
   parameter int IRQ_LINES   = irqlb_pkg::DEF_IRQ_LINES,
   parameter int COUNT_WIDTH = irqlb_pkg::DEF_COUNT_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              symmetric_mode,
   input  logic                              balancing_enable,
   input  logic [irqlb_pkg::PERIOD_W-1:0]    balance_period,
   input  logic [irqlb_pkg::ACTIVE_W-1:0]    active_cores,
   input  logic                              cmd_valid,
   input  irqlb_pkg::cmd_type                cmd_head,
   output logic                              cmd_pop,
   output logic                              init_busy,
   output logic                              rsp_push,
   output irqlb_pkg::rsp_type                rsp_data,
   input  logic                              rsp_full
);
   import irqlb_pkg::*;

   localparam int CORE_W = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
   localparam int IRQ_W  = (IRQ_LINES > 1) ? $clog2(IRQ_LINES) : 1;
   localparam int ADDR_W = CORE_W + IRQ_W;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int SCAN_W = $clog2(MAX_CORES + 1);
   localparam int LIM_W  = (SCAN_W > ACTIVE_W) ? SCAN_W : ACTIVE_W;

   engine_state_type       state_ff, state_in;
   logic [ADDR_W-1:0]      init_cnt_ff, init_cnt_in;
   logic [SCAN_W-1:0]      scan_ff, scan_in;
   cmd_type                cmd_ff, cmd_in;
   logic [COUNT_WIDTH-1:0] best_ff, best_in;
   logic [CORE_W-1:0]      best_idx_ff, best_idx_in;
   logic                   valid_ff, valid_in;
   logic                   clear_ff, clear_in;

   logic [COUNT_WIDTH-1:0] mem [DEPTH];
   logic [COUNT_WIDTH-1:0] rdata_ff;
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_waddr, mem_raddr;
   logic [COUNT_WIDTH-1:0] mem_wdata;

   logic                   rem_start;
   rem_status_type         rem_status;
   logic [COUNT_WIDTH-1:0] cnt_next;
   logic [LIM_W-1:0]       act_ext;
   logic [SCAN_W-1:0]      n_lim;
   logic [ADDR_W-1:0]      cmd_addr, head_addr, scan_addr;

   // remainder of the new count by the period
   irqlb_rem #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (cnt_next),
      .divisor  (balance_period),
      .status   (rem_status)
   );

   // scan limit, saturated to the table size
   always_comb begin
      act_ext = LIM_W'(active_cores);
      if (act_ext > LIM_W'(MAX_CORES)) begin
         n_lim = SCAN_W'(MAX_CORES);
      end else begin
         n_lim = SCAN_W'(act_ext);
      end
   end

   // table addresses: core row, irq column
   assign cmd_addr  = {CORE_W'(cmd_ff.core_id), IRQ_W'(cmd_ff.irq)};
   assign head_addr = {CORE_W'(cmd_head.core_id), IRQ_W'(cmd_head.irq)};
   assign scan_addr = {CORE_W'(scan_ff), IRQ_W'(cmd_ff.irq)};
   assign cnt_next  = rdata_ff + COUNT_WIDTH'(1);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      init_cnt_in = init_cnt_ff;
      scan_in     = scan_ff;
      cmd_in      = cmd_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      valid_in    = valid_ff;
      clear_in    = clear_ff;
      mem_we      = 1'b0;
      mem_waddr   = cmd_addr;
      mem_wdata   = '0;
      mem_raddr   = cmd_addr;
      cmd_pop     = 1'b0;
      rem_start   = 1'b0;
      rsp_push    = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            mem_we      = 1'b1;
            mem_waddr   = init_cnt_ff;
            init_cnt_in = init_cnt_ff + ADDR_W'(1);
            if (&init_cnt_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            mem_raddr = head_addr;
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_head;
               valid_in = 1'b0;
               clear_in = 1'b0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (cmd_ff.in_range) begin
               mem_we    = 1'b1;
               mem_wdata = cnt_next;
            end
            if (cmd_ff.in_range && balancing_enable && cmd_ff.allow_balance &&
                cnt_next != '0 && balance_period != '0) begin
               rem_start = 1'b1;
               state_in  = ST_MOD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MOD: begin
            if (rem_status.done) begin
               if (rem_status.zero) begin
                  scan_in     = '0;
                  best_in     = '1;
                  best_idx_in = '0;
                  valid_in    = 1'b1;
                  state_in    = ST_SCAN_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN_RD: begin
            mem_raddr = scan_addr;
            if (scan_ff == n_lim) begin
               scan_in  = '0;
               state_in = clear_ff ? ST_CLEAR : ST_DONE;
            end else begin
               state_in = ST_SCAN_CMP;
            end
         end
         ST_SCAN_CMP: begin
            if (rdata_ff < best_ff) begin
               best_in     = rdata_ff;
               best_idx_in = CORE_W'(scan_ff);
            end else if (&rdata_ff[COUNT_WIDTH-1:1]) begin
               clear_in = 1'b1;
            end
            scan_in  = scan_ff + SCAN_W'(1);
            state_in = ST_SCAN_RD;
         end
         ST_CLEAR: begin
            mem_waddr = scan_addr;
            if (scan_ff == n_lim) begin
               state_in = ST_DONE;
            end else begin
               mem_we  = 1'b1;
               scan_in = scan_ff + SCAN_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result item
   always_comb begin
      rsp_data.eoi_to_local_apic = symmetric_mode;
      rsp_data.route_valid       = valid_ff;
      rsp_data.route_irq         = valid_ff ? cmd_ff.irq : '0;
      rsp_data.route_core        = valid_ff ? CORE_ID_W'(best_idx_ff) : '0;
      rsp_data.counts_cleared    = clear_ff;
   end

   assign init_busy = (state_ff == ST_INIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_INIT;
         init_cnt_ff <= '0;
         valid_ff    <= 1'b0;
         clear_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         init_cnt_ff <= init_cnt_in;
         valid_ff    <= valid_in;
         clear_ff    <= clear_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      cmd_ff      <= cmd_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
   end

   // counter table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into full queue");

   a_rem_start_idle: assert property (@(posedge clock) disable iff (reset)
      rem_start |-> !rem_status.busy)
      else $error("remainder unit restarted while busy");

   a_clear_needs_route: assert property (@(posedge clock) disable iff (reset)
      rsp_push && !rsp_data.route_valid |-> !rsp_data.counts_cleared)
      else $error("counts cleared without a route");

endmodule
`default_nettype wire

// ===== rtl/irq_least_loaded_core_router.sv =====
`default_nettype none
// channel   ports                                    transfer when
// --------  ---------------------------------------  ---------------------------
// request   req_push, req_full, req_core_id,         req_push && !req_full
//           req_irq, req_allow_balance
// response  rsp_empty, rsp_pop, rsp_eoi_to_local_apic, rsp_pop && !rsp_empty
//           rsp_route_valid/irq/core, rsp_counts_cleared
// csr       csr_valid, csr_ready, csr_index, csr_data  csr_valid && csr_ready
//
// after reset the counter table is zeroed one entry a cycle, all of its
// 2**(clog2(MAX_CORES)+clog2(IRQ_LINES)) entries (256 by default); req_full holds
// high meanwhile.
// an item goes through the engine's read and done states and waits in done while the
// response queue is full; with a rebalance check it also passes the bit-serial remainder,
// a scan of the active cores and, when a count nears overflow, a column clear, both scan
// and clear walking the counter table one core at a time.
// a two-entry request queue and a two-entry response queue let each side stall alone.
module irq_least_loaded_core_router #(
   parameter int MAX_CORES   = irqlb_pkg::DEF_MAX_CORES,
   parameter int IRQ_LINES   = irqlb_pkg::DEF_IRQ_LINES,
   parameter int COUNT_WIDTH = irqlb_pkg::DEF_COUNT_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [irqlb_pkg::CORE_ID_W-1:0]    req_core_id,
   input  logic [irqlb_pkg::IRQ_ID_W-1:0]     req_irq,
   input  logic                               req_allow_balance,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic                               rsp_eoi_to_local_apic,
   output logic                               rsp_route_valid,
   output logic [irqlb_pkg::IRQ_ID_W-1:0]     rsp_route_irq,
   output logic [irqlb_pkg::CORE_ID_W-1:0]    rsp_route_core,
   output logic                               rsp_counts_cleared,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [irqlb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [irqlb_pkg::CSR_DATA_W-1:0]   csr_data
);
   import irqlb_pkg::*;

   logic                symmetric_mode_ff, symmetric_mode_in;
   logic                balancing_enable_ff, balancing_enable_in;
   logic [PERIOD_W-1:0] balance_period_ff, balance_period_in;
   logic [ACTIVE_W-1:0] active_cores_ff, active_cores_in;
   logic                csr_wr;

   logic                cmd_valid, cmd_pop, init_busy;
   cmd_type             cmd_head;
   logic                rsp_push, rsp_full;
   rsp_type             rsp_data;

   rsp_type             rq_ff [2];
   logic                rwr_ptr_ff, rwr_ptr_in;
   logic                rrd_ptr_ff, rrd_ptr_in;
   logic [1:0]          rcnt_ff, rcnt_in;
   logic                rsp_take;
   rsp_type             rsp_head;

   // configuration registers
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_comb begin
      symmetric_mode_in   = symmetric_mode_ff;
      balancing_enable_in = balancing_enable_ff;
      balance_period_in   = balance_period_ff;
      active_cores_in     = active_cores_ff;
      if (csr_wr) begin
         unique case (csr_index)
            CSR_SYMMETRIC_MODE:   symmetric_mode_in   = csr_data[0];
            CSR_BALANCING_ENABLE: balancing_enable_in = csr_data[0];
            CSR_BALANCE_PERIOD:   balance_period_in   = csr_data[PERIOD_W-1:0];
            CSR_ACTIVE_CORES:     active_cores_in     = csr_data[ACTIVE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         symmetric_mode_ff   <= 1'b0;
         balancing_enable_ff <= 1'b0;
         balance_period_ff   <= RST_BALANCE_PERIOD;
         active_cores_ff     <= RST_ACTIVE_CORES;
      end else begin
         symmetric_mode_ff   <= symmetric_mode_in;
         balancing_enable_ff <= balancing_enable_in;
         balance_period_ff   <= balance_period_in;
         active_cores_ff     <= active_cores_in;
      end
   end

   // front: accept and classify
   irqlb_front #(
      .MAX_CORES (MAX_CORES),
      .IRQ_LINES (IRQ_LINES)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_core_id       (req_core_id),
      .req_irq           (req_irq),
      .req_allow_balance (req_allow_balance),
      .stall             (init_busy),
      .cmd_valid         (cmd_valid),
      .cmd_head          (cmd_head),
      .cmd_pop           (cmd_pop)
   );

   // back: count, check and rebalance
   irqlb_engine #(
      .MAX_CORES   (MAX_CORES),
      .IRQ_LINES   (IRQ_LINES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .symmetric_mode   (symmetric_mode_ff),
      .balancing_enable (balancing_enable_ff),
      .balance_period   (balance_period_ff),
      .active_cores     (active_cores_ff),
      .cmd_valid        (cmd_valid),
      .cmd_head         (cmd_head),
      .cmd_pop          (cmd_pop),
      .init_busy        (init_busy),
      .rsp_push         (rsp_push),
      .rsp_data         (rsp_data),
      .rsp_full         (rsp_full)
   );

   // response queue
   assign rsp_full  = (rcnt_ff == 2'd2);
   assign rsp_empty = (rcnt_ff == 2'd0);
   assign rsp_take  = rsp_pop && !rsp_empty;
   assign rsp_head  = rq_ff[rrd_ptr_ff];

   always_comb begin
      rwr_ptr_in = rsp_push ? !rwr_ptr_ff : rwr_ptr_ff;
      rrd_ptr_in = rsp_take ? !rrd_ptr_ff : rrd_ptr_ff;
      rcnt_in    = rcnt_ff + {1'b0, rsp_push} - {1'b0, rsp_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rwr_ptr_ff <= 1'b0;
         rrd_ptr_ff <= 1'b0;
         rcnt_ff    <= 2'd0;
      end else begin
         rwr_ptr_ff <= rwr_ptr_in;
         rrd_ptr_ff <= rrd_ptr_in;
         rcnt_ff    <= rcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         rq_ff[rwr_ptr_ff] <= rsp_data;
      end
   end

   assign rsp_eoi_to_local_apic = rsp_head.eoi_to_local_apic;
   assign rsp_route_valid       = rsp_head.route_valid;
   assign rsp_route_irq         = rsp_head.route_irq;
   assign rsp_route_core        = rsp_head.route_core;
   assign rsp_counts_cleared    = rsp_head.counts_cleared;

endmodule
`default_nettype wire

// ===== bench/irq_least_loaded_core_router_tb.sv =====
`timescale 1ns / 1ps

// tracks the per-core interrupt counters and predicts each routing decision
class route_scoreboard;
   localparam int CORES = irqlb_pkg::DEF_MAX_CORES;
   localparam int LINES = irqlb_pkg::DEF_IRQ_LINES;

   logic [irqlb_pkg::DEF_COUNT_WIDTH-1:0] counts [CORES][LINES];
   logic                                  sym_mode;
   logic                                  bal_on;
   logic [irqlb_pkg::PERIOD_W-1:0]        period;
   logic [irqlb_pkg::ACTIVE_W-1:0]        active;
   irqlb_pkg::rsp_type                    expected_routes [$];
   int unsigned                           errors;
   int unsigned                           checked;
   int unsigned                           reroutes;

   function new();
      foreach (counts[c, q]) counts[c][q] = '0;
      sym_mode = 1'b0;
      bal_on   = 1'b0;
      period   = irqlb_pkg::RST_BALANCE_PERIOD;
      active   = irqlb_pkg::RST_ACTIVE_CORES;
      errors   = 0;
      checked  = 0;
      reroutes = 0;
   endfunction

   function int unsigned pending();
      return expected_routes.size();
   endfunction

   // register write as the block sees it, upper data bits dropped
   function void write_reg(logic [irqlb_pkg::CSR_IDX_W-1:0] idx,
                           logic [irqlb_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         irqlb_pkg::CSR_SYMMETRIC_MODE:   sym_mode = data[0];
         irqlb_pkg::CSR_BALANCING_ENABLE: bal_on   = data[0];
         irqlb_pkg::CSR_BALANCE_PERIOD:   period   = data[irqlb_pkg::PERIOD_W-1:0];
         irqlb_pkg::CSR_ACTIVE_CORES:     active   = data[irqlb_pkg::ACTIVE_W-1:0];
         default: ;
      endcase
   endfunction

   // count the serviced interrupt and work out the routing result
   function void note_request(logic [3:0] core, logic [3:0] irq, logic allow);
      irqlb_pkg::rsp_type                    want;
      logic [irqlb_pkg::DEF_COUNT_WIDTH-1:0] cnt;
      logic [irqlb_pkg::DEF_COUNT_WIDTH-1:0] best;
      int unsigned                           best_core;
      int unsigned                           span;
      bit                                    wipe;
      want = '0;
      want.eoi_to_local_apic = sym_mode;
      if (core < CORES && irq < LINES) begin
         cnt = counts[core][irq] + {{(irqlb_pkg::DEF_COUNT_WIDTH-1){1'b0}}, 1'b1};
         counts[core][irq] = cnt;
         if (bal_on && allow && cnt != 0 && period != 0 && (cnt % period) == 0) begin
            span      = (active > CORES) ? CORES : active;
            best      = '1;
            best_core = 0;
            wipe      = 1'b0;
            // least loaded scan, ties stay on the lower core
            for (int i = 0; i < span; i++) begin
               if (counts[i][irq] < best) begin
                  best      = counts[i][irq];
                  best_core = i;
               end else if (counts[i][irq] >= {{(irqlb_pkg::DEF_COUNT_WIDTH-1){1'b1}}, 1'b0}) begin
                  wipe = 1'b1;
               end
            end
            if (wipe) begin
               for (int i = 0; i < span; i++) counts[i][irq] = '0;
            end
            want.route_valid    = 1'b1;
            want.route_irq      = irq;
            want.route_core     = best_core[3:0];
            want.counts_cleared = wipe;
            reroutes++;
         end
      end
      expected_routes.push_back(want);
   endfunction

   function void compare_field(string name, int unsigned want, int unsigned seen);
      if (want != seen) begin
         $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, seen);
         errors++;
      end
   endfunction

   // compare one popped response with the oldest prediction
   function void check_response(irqlb_pkg::rsp_type seen);
      irqlb_pkg::rsp_type want;
      if (expected_routes.size() == 0) begin
         $display("%0t mismatch unexpected response: expected none actual %h", $time, seen);
         errors++;
         return;
      end
      want = expected_routes.pop_front();
      checked++;
      compare_field("eoi_to_local_apic", want.eoi_to_local_apic, seen.eoi_to_local_apic);
      compare_field("route_valid", want.route_valid, seen.route_valid);
      compare_field("route_irq", want.route_irq, seen.route_irq);
      compare_field("route_core", want.route_core, seen.route_core);
      compare_field("counts_cleared", want.counts_cleared, seen.counts_cleared);
   endfunction
endclass

module irq_least_loaded_core_router_tb;
   import irqlb_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int          PHASES      = 8;
   localparam int          PHASE_ITEMS = 54;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_push;
   logic                  req_full;
   logic [CORE_ID_W-1:0]  req_core_id;
   logic [IRQ_ID_W-1:0]   req_irq;
   logic                  req_allow_balance;
   logic                  rsp_empty;
   logic                  rsp_pop;
   logic                  rsp_eoi_to_local_apic;
   logic                  rsp_route_valid;
   logic [IRQ_ID_W-1:0]   rsp_route_irq;
   logic [CORE_ID_W-1:0]  rsp_route_core;
   logic                  rsp_counts_cleared;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   route_scoreboard sb;
   rsp_type         rsp_seen;
   int unsigned     send_idle_pct;
   int unsigned     pop_stall_pct;
   int unsigned     cycle_count;
   int unsigned     settings_used;
   logic [3:0]      hot_irqs [3];
   int unsigned     core_span;

   irq_least_loaded_core_router uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_push              (req_push),
      .req_full              (req_full),
      .req_core_id           (req_core_id),
      .req_irq               (req_irq),
      .req_allow_balance     (req_allow_balance),
      .rsp_empty             (rsp_empty),
      .rsp_pop               (rsp_pop),
      .rsp_eoi_to_local_apic (rsp_eoi_to_local_apic),
      .rsp_route_valid       (rsp_route_valid),
      .rsp_route_irq         (rsp_route_irq),
      .rsp_route_core        (rsp_route_core),
      .rsp_counts_cleared    (rsp_counts_cleared),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   assign rsp_seen = {rsp_eoi_to_local_apic, rsp_route_valid, rsp_route_irq,
                      rsp_route_core, rsp_counts_cleared};

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, sb.pending());
         $display("tb: failure");
         $finish;
      end
   end

   // response side: random stalls, check every popped transfer
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) sb.check_response(rsp_seen);
         rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   // one interrupt report, held until the block takes it
   task automatic send_request(input logic [3:0] core, input logic [3:0] irq,
                               input logic allow);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push          <= 1'b1;
      req_core_id       <= core;
      req_irq           <= irq;
      req_allow_balance <= allow;
      do @(posedge clock); while (req_full);
      sb.note_request(core, irq, allow);
   endtask

   // drain, then write all four registers; junk goes in the unused data bits
   task automatic configure(input logic sym, input logic bal,
                            input logic [PERIOD_W-1:0] period,
                            input logic [ACTIVE_W-1:0] active);
      logic [CSR_IDX_W-1:0]  idx  [4];
      logic [CSR_DATA_W-1:0] data [4];
      idx[0]  = CSR_SYMMETRIC_MODE;
      idx[1]  = CSR_BALANCING_ENABLE;
      idx[2]  = CSR_BALANCE_PERIOD;
      idx[3]  = CSR_ACTIVE_CORES;
      data[0] = {15'($urandom), sym};
      data[1] = {15'($urandom), bal};
      data[2] = period;
      data[3] = {11'($urandom), active};
      req_push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= data[i];
         do @(posedge clock); while (!csr_ready);
         sb.write_reg(idx[i], data[i]);
      end
      csr_valid <= 1'b0;
      settings_used++;
      core_span = (active == 0) ? 1 : (active > 16) ? 16 : int'(active);
   endtask

   // mostly bursts on a few hot lines over the scanned cores, some noise
   task automatic pick_request(output logic [3:0] core, output logic [3:0] irq,
                               output logic allow);
      if ($urandom_range(99) < 75) begin
         irq   = hot_irqs[$urandom_range(2)];
         core  = 4'($urandom_range(core_span - 1));
         allow = ($urandom_range(9) != 0);
      end else begin
         core  = 4'($urandom);
         irq   = 4'($urandom);
         allow = 1'($urandom);
      end
   endtask

   initial begin
      logic [3:0]  core;
      logic [3:0]  irq;
      logic        allow;
      logic [15:0] period;
      logic [4:0]  active;
      sb                = new();
      reset             = 1'b1;
      req_push          = 1'b0;
      req_core_id       = '0;
      req_irq           = '0;
      req_allow_balance = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = '0;
      csr_data          = '0;
      cycle_count       = 0;
      settings_used     = 0;
      send_idle_pct     = 0;
      pop_stall_pct     = 0;
      core_span         = 1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // register defaults: balancing off, eoi to the pic
      send_request(4'd0, 4'd0, 1'b1);
      send_request(4'd15, 4'd15, 1'b1);

      // every item that allows balancing rebalances over all sixteen cores
      configure(1'b1, 1'b1, 16'd1, 5'd16);
      send_request(4'd0, 4'd0, 1'b1);   // tie among idle cores goes to core 1
      send_request(4'd1, 4'd0, 1'b1);   // cores 0 and 1 loaded, core 2 wins
      send_request(4'd15, 4'd15, 1'b1);
      send_request(4'd15, 4'd15, 1'b0); // handler without balancing
      send_request(4'd8, 4'd7, 1'b1);
      send_request(4'd0, 4'd15, 1'b1);

      // zero period never rebalances
      configure(1'b0, 1'b1, 16'd0, 5'd31);
      send_request(4'd3, 4'd3, 1'b1);
      send_request(4'd3, 4'd3, 1'b1);

      // active core count above the table saturates
      configure(1'b1, 1'b1, 16'd2, 5'd31);
      send_request(4'd5, 4'd9, 1'b1);
      send_request(4'd5, 4'd9, 1'b1);
      send_request(4'd2, 4'd9, 1'b1);
      send_request(4'd2, 4'd9, 1'b1);

      // no core scanned, route falls back to core 0
      configure(1'b0, 1'b1, 16'd1, 5'd0);
      send_request(4'd9, 4'd1, 1'b1);
      send_request(4'd0, 4'd1, 1'b0);

      // largest period, single core
      configure(1'b1, 1'b1, 16'hFFFF, 5'd1);
      send_request(4'd0, 4'd0, 1'b1);

      // balancing disabled again
      configure(1'b0, 1'b0, 16'd1, 5'd16);
      send_request(4'd4, 4'd4, 1'b1);

      // random phases, each with its own settings and idling pattern
      for (int p = 0; p < PHASES; p++) begin
         case ($urandom_range(9))
            0:       period = 16'd0;
            1:       period = 16'hFFFF;
            2:       period = 16'($urandom_range(40, 5));
            default: period = 16'($urandom_range(4, 1));
         endcase
         case ($urandom_range(7))
            0:       active = 5'd0;
            1:       active = 5'($urandom_range(31, 17));
            2:       active = 5'd16;
            default: active = 5'($urandom_range(15, 1));
         endcase
         configure(1'($urandom_range(1)), ($urandom_range(9) != 0), period, active);
         for (int h = 0; h < 3; h++) hot_irqs[h] = 4'($urandom);
         case (p % 4)
            0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
            1: begin send_idle_pct = 57; pop_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  pop_stall_pct = 57; end
            default: begin send_idle_pct = 22; pop_stall_pct = 22; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick_request(core, irq, allow);
            send_request(core, irq, allow);
         end
      end

      // drain and let any stray response show up
      req_push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("covered %0d interrupt transfers under %0d register settings",
               sb.checked, settings_used);
      $display("%0d reroutes predicted, %0d mismatches", sb.reroutes, sb.errors);
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
